@@ src/c8fd_pkg.sv @@
// Shared types, codes and the CRC-8 byte update for the frame deframer.
`default_nettype none
package c8fd_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SOF_BYTE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd1;

    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef enum logic [2:0] {
        KIND_BYTE    = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_LEN_ERR = 3'd2,
        KIND_CRC_ERR = 3'd3,
        KIND_MORE    = 3'd4
    } kind_t;

    // One received byte held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
        logic       chunk_end;
    } in_item_t;

    // MSB-first CRC-8, one byte per call, unrolled over the eight bits.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ src/c8fd_in_stage.sv @@
// Input register: holds one received byte until the parser takes it.
`default_nettype none
module c8fd_in_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              chunk_end,
    input  wire logic              take,
    output c8fd_pkg::in_item_t     item
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       load;

    // Refill whenever the register is empty or its byte leaves this cycle.
    assign load     = in_valid && (!valid_reg || take);
    assign in_stall = valid_reg && !take;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
            end_reg  <= chunk_end;
        end
    end

    assign item.valid     = valid_reg;
    assign item.rx_byte   = byte_reg;
    assign item.chunk_end = end_reg;

endmodule
`default_nettype wire

@@ src/c8fd_parser.sv @@
// Frame parser: phase machine, running CRC, frame counters and result register.
`default_nettype none
module c8fd_parser
#(
    parameter int COUNTER_WIDTH = c8fd_pkg::COUNTER_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire c8fd_pkg::in_item_t item,
    output logic                    take,
    input  wire logic [7:0]         sof_byte,
    input  wire logic [15:0]        max_payload,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              kind,
    output logic [7:0]              data_byte,
    output logic [15:0]             byte_index,
    output logic [7:0]              command,
    output logic [7:0]              sequence_res,
    output logic [15:0]             frame_payload_len,
    output logic [31:0]             good_frames,
    output logic [31:0]             bad_frames
);

    typedef enum logic [6:0] {
        PH_HUNT    = 7'b0000001,
        PH_LEN_LO  = 7'b0000010,
        PH_LEN_HI  = 7'b0000100,
        PH_CMD     = 7'b0001000,
        PH_SEQ     = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_CRC     = 7'b1000000
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [15:0]              len_reg, len_next;
    logic [15:0]              cnt_reg, cnt_next;
    logic [7:0]               crc_reg, crc_next;
    logic [7:0]               cmd_reg, cmd_next;
    logic [7:0]               seq_reg, seq_next;
    logic [COUNTER_WIDTH-1:0] good_reg, good_next;
    logic [COUNTER_WIDTH-1:0] bad_reg, bad_next;
    logic                     out_valid_reg, out_valid_next;

    // Result payload registers.
    logic [2:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [15:0] index_reg;
    logic [7:0]  rcmd_reg;
    logic [7:0]  rseq_reg;
    logic [15:0] rlen_reg;
    logic [31:0] rgood_reg;
    logic [31:0] rbad_reg;

    logic                     has_res;
    c8fd_pkg::kind_t          res_kind;
    logic [7:0]               res_data;
    logic [15:0]              res_index;
    logic [15:0]              res_len;
    logic [7:0]               b;
    logic [7:0]               crc_upd;
    logic [15:0]              len_full;
    logic [15:0]              cnt_inc;

    assign take    = item.valid && (!out_valid_reg || !out_stall);
    assign b       = item.rx_byte;
    assign crc_upd = c8fd_pkg::crc8_next(crc_reg, b);
    assign len_full = {b, len_reg[7:0]};
    assign cnt_inc  = cnt_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        seq_next   = seq_reg;
        good_next  = good_reg;
        bad_next   = bad_reg;
        has_res    = 1'b0;
        res_kind   = c8fd_pkg::KIND_MORE;
        res_data   = 8'd0;
        res_index  = 16'd0;
        res_len    = 16'd0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (b == sof_byte)
                begin
                    len_next   = 16'd0;
                    cnt_next   = 16'd0;
                    cmd_next   = 8'd0;
                    seq_next   = 8'd0;
                    crc_next   = c8fd_pkg::crc8_next(8'd0, b);
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                crc_next   = crc_upd;
                len_next   = {8'd0, b};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                crc_next = crc_upd;
                if (len_full > max_payload)
                begin
                    // Report the rejected length, then drop back to hunting.
                    bad_next   = bad_reg + 1'b1;
                    has_res    = 1'b1;
                    res_kind   = c8fd_pkg::KIND_LEN_ERR;
                    res_len    = len_full;
                    len_next   = 16'd0;
                    cnt_next   = 16'd0;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    len_next   = len_full;
                    phase_next = PH_CMD;
                end
            end
            PH_CMD:
            begin
                crc_next   = crc_upd;
                cmd_next   = b;
                phase_next = PH_SEQ;
            end
            PH_SEQ:
            begin
                crc_next   = crc_upd;
                seq_next   = b;
                phase_next = (len_reg == 16'd0) ? PH_CRC : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                crc_next  = crc_upd;
                has_res   = 1'b1;
                res_kind  = c8fd_pkg::KIND_BYTE;
                res_data  = b;
                res_index = cnt_reg;
                res_len   = len_reg;
                cnt_next  = cnt_inc;
                if (cnt_inc >= len_reg)
                    phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                has_res = 1'b1;
                res_len = len_reg;
                if (crc_reg == b)
                begin
                    good_next = good_reg + 1'b1;
                    res_kind  = c8fd_pkg::KIND_GOOD;
                end
                else
                begin
                    bad_next = bad_reg + 1'b1;
                    res_kind = c8fd_pkg::KIND_CRC_ERR;
                end
                len_next   = 16'd0;
                cnt_next   = 16'd0;
                phase_next = PH_HUNT;
            end
            default:
            begin
                len_next   = 16'd0;
                cnt_next   = 16'd0;
                phase_next = PH_HUNT;
            end
        endcase

        // End of chunk with nothing else to say: ask for more.
        if (!has_res && item.chunk_end)
        begin
            has_res  = 1'b1;
            res_kind = c8fd_pkg::KIND_MORE;
            res_len  = len_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = has_res;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            len_reg       <= 16'd0;
            cnt_reg       <= 16'd0;
            crc_reg       <= 8'd0;
            cmd_reg       <= 8'd0;
            seq_reg       <= 8'd0;
            good_reg      <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                cnt_reg   <= cnt_next;
                crc_reg   <= crc_next;
                cmd_reg   <= cmd_next;
                seq_reg   <= seq_next;
                good_reg  <= good_next;
                bad_reg   <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && has_res)
        begin
            kind_reg  <= res_kind;
            data_reg  <= res_data;
            index_reg <= res_index;
            rcmd_reg  <= cmd_next;
            rseq_reg  <= seq_next;
            rlen_reg  <= res_len;
            rgood_reg <= 32'(good_next);
            rbad_reg  <= 32'(bad_next);
        end
    end

    assign out_valid         = out_valid_reg;
    assign kind              = kind_reg;
    assign data_byte         = data_reg;
    assign byte_index        = index_reg;
    assign command           = rcmd_reg;
    assign sequence_res      = rseq_reg;
    assign frame_payload_len = rlen_reg;
    assign good_frames       = rgood_reg;
    assign bad_frames        = rbad_reg;

endmodule
`default_nettype wire

@@ src/crc8_frame_deframer.sv @@
// Top level of the byte-serial frame deframer with CRC-8 check.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   input   | in        | in_valid / in_stall  | rx_byte, chunk_end
//   result  | out       | out_valid / out_stall| kind, data_byte, byte_index, command,
//           |           |                      | sequence_res, frame_payload_len,
//           |           |                      | good_frames, bad_frames
//   config  | in        | cfg_we               | cfg_index, cfg_data
//
// One byte is taken every cycle while the result register is empty or not stalled; a byte
// waits in the input register until the parser takes it, and its result (if any) is then
// loaded into the result register, from which it transfers.
// The single pass through the phase logic and the unrolled CRC-8 XOR tree sets that rate.
// Reset clears the phase machine, CRC, held header fields, counters and both valid flags;
// the start byte returns to 0xAA and the maximum payload to 255.
// A stalled result holds the parser; the input register then absorbs at most one more transfer
// before in_stall rises.
`default_nettype none
module crc8_frame_deframer
#(
    parameter int COUNTER_WIDTH = c8fd_pkg::COUNTER_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [c8fd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [c8fd_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            chunk_end,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [2:0]                           kind,
    output logic [7:0]                           data_byte,
    output logic [15:0]                          byte_index,
    output logic [7:0]                           command,
    output logic [7:0]                           sequence_res,
    output logic [15:0]                          frame_payload_len,
    output logic [31:0]                          good_frames,
    output logic [31:0]                          bad_frames
);

    logic [7:0]          sof_reg;
    logic [15:0]         max_len_reg;
    c8fd_pkg::in_item_t  item;
    logic                take;

    // Configuration registers: written by the user only while the block is idle; unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_reg     <= 8'hAA;
            max_len_reg <= 16'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                c8fd_pkg::CFG_SOF_BYTE:    sof_reg     <= cfg_data[7:0];
                c8fd_pkg::CFG_MAX_PAYLOAD: max_len_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Hold the incoming byte until the parser can advance.
    c8fd_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .chunk_end (chunk_end),
        .take      (take),
        .item      (item)
    );

    // Parse the frame, update CRC and counters, register the result.
    c8fd_parser
    #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    )
    u_parser
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .item              (item),
        .take              (take),
        .sof_byte          (sof_reg),
        .max_payload       (max_len_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .data_byte         (data_byte),
        .byte_index        (byte_index),
        .command           (command),
        .sequence_res      (sequence_res),
        .frame_payload_len (frame_payload_len),
        .good_frames       (good_frames),
        .bad_frames        (bad_frames)
    );

endmodule
`default_nettype wire

@@ dv/crc8_frame_deframer_checker.sv @@
// Result checker for the CRC-8 frame deframer: tracks parse state and compares every result.
`default_nettype none
module crc8_frame_deframer_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [c8fd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [c8fd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            chunk_end,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [2:0]                      kind,
    input  wire logic [7:0]                      data_byte,
    input  wire logic [15:0]                     byte_index,
    input  wire logic [7:0]                      command,
    input  wire logic [7:0]                      sequence_res,
    input  wire logic [15:0]                     frame_payload_len,
    input  wire logic [31:0]                     good_frames,
    input  wire logic [31:0]                     bad_frames,
    output int                                   fail_count,
    output int                                   pending_count
);

    localparam logic [7:0]  SOF_AT_RESET = 8'hAA;
    localparam logic [15:0] MAX_AT_RESET = 16'd255;

    typedef enum logic [2:0] {
        HUNT, LEN_LO, LEN_HI, CMD, SEQ, PAYLOAD, TRAILER
    } parse_phase_t;

    typedef struct packed {
        c8fd_pkg::kind_t res_kind;
        logic [7:0]      res_data;
        logic [15:0]     res_index;
        logic [7:0]      res_command;
        logic [7:0]      res_sequence;
        logic [15:0]     res_len;
        logic [31:0]     res_good;
        logic [31:0]     res_bad;
    } frame_result_t;

    frame_result_t expected_results[$];

    logic [7:0]   sof_cfg;
    logic [15:0]  max_len_cfg;
    parse_phase_t phase;
    logic [15:0]  len_field;
    logic [15:0]  pay_count;
    logic [7:0]   crc_acc;
    logic [7:0]   cmd_hold;
    logic [7:0]   seq_hold;
    logic [31:0]  good_cnt;
    logic [31:0]  bad_cnt;

    // MSB first, polynomial x^8 + x^2 + x + 1
    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8) r = (r << 1) ^ (r[7] ? c8fd_pkg::CRC_POLY : 8'h00);
        return r;
    endfunction

    function automatic void queue_result(input c8fd_pkg::kind_t k, input logic [7:0] d,
                                         input logic [15:0] idx);
        frame_result_t r;
        r.res_kind     = k;
        r.res_data     = d;
        r.res_index    = idx;
        r.res_command  = cmd_hold;
        r.res_sequence = seq_hold;
        r.res_len      = len_field;
        r.res_good     = good_cnt;
        r.res_bad      = bad_cnt;
        expected_results.push_back(r);
    endfunction

    function automatic void rehunt();
        phase     = HUNT;
        len_field = 16'd0;
        pay_count = 16'd0;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic ce);
        logic produced;
        produced = 1'b0;
        case (phase)
            HUNT:
                if (b == sof_cfg) begin
                    len_field = 16'd0;
                    pay_count = 16'd0;
                    cmd_hold  = 8'd0;
                    seq_hold  = 8'd0;
                    crc_acc   = crc8_fold(8'h00, b);
                    phase     = LEN_LO;
                end
            LEN_LO: begin
                crc_acc   = crc8_fold(crc_acc, b);
                len_field = {8'h00, b};
                phase     = LEN_HI;
            end
            LEN_HI: begin
                crc_acc         = crc8_fold(crc_acc, b);
                len_field[15:8] = b;
                if (len_field > max_len_cfg) begin
                    bad_cnt = bad_cnt + 32'd1;
                    queue_result(c8fd_pkg::KIND_LEN_ERR, 8'h00, 16'h0000);
                    rehunt();
                    produced = 1'b1;
                end else begin
                    phase = CMD;
                end
            end
            CMD: begin
                crc_acc  = crc8_fold(crc_acc, b);
                cmd_hold = b;
                phase    = SEQ;
            end
            SEQ: begin
                crc_acc  = crc8_fold(crc_acc, b);
                seq_hold = b;
                phase    = (len_field == 16'd0) ? TRAILER : PAYLOAD;
            end
            PAYLOAD: begin
                crc_acc = crc8_fold(crc_acc, b);
                queue_result(c8fd_pkg::KIND_BYTE, b, pay_count);
                pay_count = pay_count + 16'd1;
                if (pay_count >= len_field)
                    phase = TRAILER;
                produced = 1'b1;
            end
            TRAILER: begin
                if (crc_acc == b) begin
                    good_cnt = good_cnt + 32'd1;
                    queue_result(c8fd_pkg::KIND_GOOD, 8'h00, 16'h0000);
                end else begin
                    bad_cnt = bad_cnt + 32'd1;
                    queue_result(c8fd_pkg::KIND_CRC_ERR, 8'h00, 16'h0000);
                end
                rehunt();
                produced = 1'b1;
            end
            default: rehunt();
        endcase
        if (!produced && ce)
            queue_result(c8fd_pkg::KIND_MORE, 8'h00, 16'h0000);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (seen !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, seen);
            fail_count++;
        end
    endfunction

    task automatic compare_result();
        frame_result_t want;
        if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: kind %0d", kind);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("kind", 32'(want.res_kind), 32'(kind));
            check_field("data_byte", 32'(want.res_data), 32'(data_byte));
            check_field("byte_index", 32'(want.res_index), 32'(byte_index));
            check_field("command", 32'(want.res_command), 32'(command));
            check_field("sequence_res", 32'(want.res_sequence), 32'(sequence_res));
            check_field("frame_payload_len", 32'(want.res_len), 32'(frame_payload_len));
            check_field("good_frames", want.res_good, good_frames);
            check_field("bad_frames", want.res_bad, bad_frames);
        end
    endtask

    // Results leave before this edge's byte is parsed, so compare first, then predict.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sof_cfg     = SOF_AT_RESET;
            max_len_cfg = MAX_AT_RESET;
            phase       = HUNT;
            len_field   = 16'd0;
            pay_count   = 16'd0;
            crc_acc     = 8'd0;
            cmd_hold    = 8'd0;
            seq_hold    = 8'd0;
            good_cnt    = 32'd0;
            bad_cnt     = 32'd0;
            fail_count  = 0;
            expected_results.delete();
        end else begin
            if (out_valid && !out_stall)
                compare_result();
            if (in_valid && !in_stall)
                take_byte(rx_byte, chunk_end);
            if (cfg_we) begin
                if (cfg_index == c8fd_pkg::CFG_SOF_BYTE)
                    sof_cfg = cfg_data[7:0];
                else if (cfg_index == c8fd_pkg::CFG_MAX_PAYLOAD)
                    max_len_cfg = cfg_data;
            end
        end
        pending_count = expected_results.size();
    end

endmodule
`default_nettype wire

@@ dv/crc8_frame_deframer_tb.sv @@
// Testbench top for the CRC-8 frame deframer: drives frames and noise, gives the verdict.
`default_nettype none
module crc8_frame_deframer_tb;

    localparam int CLK_HALF          = 10;
    localparam int RESET_CYCLES      = 10;
    localparam int SEGMENTS          = 6;
    localparam int ITEMS_PER_SEGMENT = 305;
    // covers the path from input register to result register, plus margin
    localparam int PIPE_CYCLES       = 4;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES      = 200_000;
    localparam int CHUNK_PCT         = 12;
    localparam int SPOIL_PCT         = 15;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [c8fd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [c8fd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      rx_byte;
    logic                            chunk_end;
    logic                            out_valid;
    logic                            out_stall;
    logic [2:0]                      kind;
    logic [7:0]                      data_byte;
    logic [15:0]                     byte_index;
    logic [7:0]                      command;
    logic [7:0]                      sequence_res;
    logic [15:0]                     frame_payload_len;
    logic [31:0]                     good_frames;
    logic [31:0]                     bad_frames;
    int                              fail_count;
    int                              pending_count;

    // Stimulus knobs; the last two are shared with the result sink.
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          long_hold_armed;
    // Generator's view of the programmed settings.
    logic [7:0]  sof_now;
    logic [15:0] max_now;
    int          frame_bytes;

    crc8_frame_deframer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .chunk_end         (chunk_end),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .data_byte         (data_byte),
        .byte_index        (byte_index),
        .command           (command),
        .sequence_res      (sequence_res),
        .frame_payload_len (frame_payload_len),
        .good_frames       (good_frames),
        .bad_frames        (bad_frames)
    );

    crc8_frame_deframer_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .chunk_end         (chunk_end),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .data_byte         (data_byte),
        .byte_index        (byte_index),
        .command           (command),
        .sequence_res      (sequence_res),
        .frame_payload_len (frame_payload_len),
        .good_frames       (good_frames),
        .bad_frames        (bad_frames),
        .fail_count        (fail_count),
        .pending_count     (pending_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run, even with both sides
    // idling heavily and the long hold-off.
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("end of test: mismatches");
        $finish;
    end

    // Result sink: stall at the current rate, or hold off for a long stretch
    // when armed so the input register fills and in_stall rises.
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_armed)
            begin
                long_hold_armed = 1'b0;
                hold_left       = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offer one byte and hold it until the transfer completes. Valid stays
    // high on return so back-to-back bytes need no second assignment.
    task automatic send_byte(input logic [7:0] b, input logic ce);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        chunk_end <= ce;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Send a frame with random header bytes and payload. Stop after the
    // length bytes when the length is too large (the parser is hunting again),
    // or after cut bytes when cut is not negative. Spoil flips a trailer bit.
    task automatic send_frame(input logic [15:0] len, input bit spoil, input int cut,
                              input int ce_pct);
        logic [7:0] crc;
        logic [7:0] b;
        int         total;
        crc   = 8'h00;
        total = (len > max_now) ? 3 : 6 + int'(len);
        if (cut >= 0 && cut < total)
            total = cut;
        for (int i = 0; i < total; i++)
        begin
            if (i == 0)
                b = sof_now;
            else if (i == 1)
                b = len[7:0];
            else if (i == 2)
                b = len[15:8];
            else if (i == 5 + int'(len))
                b = spoil ? crc ^ (8'h01 << $urandom_range(7)) : crc;
            else
                b = 8'($urandom_range(255));
            crc = c8fd_pkg::crc8_next(crc, b);
            send_byte(b, $urandom_range(99) < ce_pct);
            frame_bytes++;
        end
    endtask

    // Mostly short payloads; now and then a longer one up to 300 bytes.
    function automatic logic [15:0] pick_length();
        int hi;
        hi = (int'(max_now) < 12) ? int'(max_now) : 12;
        if (int'(max_now) > 12 && $urandom_range(29) == 0)
            hi = (int'(max_now) < 300) ? int'(max_now) : 300;
        return 16'($urandom_range(hi));
    endfunction

    // Drop valid, wait out every expected result and the pipeline behind it.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on consecutive edges; write enable stays high for both, then drops.
    task automatic apply_settings(input logic [7:0] sof, input logic [15:0] max_len);
        cfg_we    <= 1'b1;
        cfg_index <= c8fd_pkg::CFG_SOF_BYTE;
        cfg_data  <= {8'h00, sof};
        @(posedge clk);
        cfg_index <= c8fd_pkg::CFG_MAX_PAYLOAD;
        cfg_data  <= max_len;
        @(posedge clk);
        cfg_we  <= 1'b0;
        sof_now  = sof;
        max_now  = max_len;
    endtask

    initial
    begin : stimulus
        int          seg_end;
        int          pick;
        bit          wide;
        logic [15:0] len;
        logic [7:0]  b;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= c8fd_pkg::CFG_SOF_BYTE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        chunk_end <= 1'b0;
        send_idle_pct   = 13;
        recv_idle_pct   = 55;
        long_hold_armed = 1'b0;
        sof_now         = 8'hAA;
        max_now         = 16'd255;
        frame_bytes     = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset settings: noise while hunting (one with
        // a chunk end), a zero-length frame with every byte ending a chunk,
        // a length just above the maximum, a bad trailer, a good short frame.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_frame(16'd0, 1'b0, -1, 100);
        send_frame(16'h0100, 1'b0, -1, 0);
        send_frame(16'd2, 1'b1, -1, 100);
        send_frame(16'd1, 1'b0, -1, 0);
        drain();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // Sender idles lightly first, then the receiver, then neither.
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct = 55;
                end
                1:
                begin
                    send_idle_pct = 55;
                    recv_idle_pct = 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (seg)
                0: apply_settings(8'h00, 16'd0);
                1: apply_settings(8'($urandom_range(255)), 16'd20);
                2: apply_settings(8'hFF, 16'hFFFF);
                3: apply_settings(8'($urandom_range(255)), 16'($urandom_range(64, 1)));
                4: apply_settings(8'hAA, 16'd255);
                default: apply_settings(8'($urandom_range(255)), 16'd300);
            endcase
            if (seg == 0 || seg == 4)
                long_hold_armed = 1'b1;

            // With a large maximum a stray start byte could open a frame whose
            // length runs into the thousands; keep noise clear of it then.
            wide    = (max_now > 16'd255);
            seg_end = frame_bytes + ITEMS_PER_SEGMENT;
            while (frame_bytes < seg_end)
            begin
                pick = $urandom_range(99);
                len  = pick_length();
                if (pick < 70)
                begin
                    send_frame(len, $urandom_range(99) < SPOIL_PCT, -1, CHUNK_PCT);
                end
                else if (pick < 80 && !wide)
                begin
                    // broken frame: cut short, the next bytes land mid-frame
                    send_frame(len, 1'b0, $urandom_range(5, 1), CHUNK_PCT);
                end
                else if (pick < 90 && max_now != 16'hFFFF)
                begin
                    send_frame(16'($urandom_range(65535, int'(max_now) + 1)), 1'b0, -1,
                               CHUNK_PCT);
                end
                else
                begin
                    repeat ($urandom_range(4, 1))
                    begin
                        b = 8'($urandom_range(255));
                        if (wide && b == sof_now)
                            b = ~b;
                        send_byte(b, $urandom_range(99) < CHUNK_PCT);
                        frame_bytes++;
                    end
                end
            end
            drain();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
